/* hdl/csf_pkg.sv */
// Shared types, codes and command tables of the flash command interface.
`timescale 1ns / 1ps
package csf_pkg;

    localparam int ADDR_BITS = 24;
    localparam int MOD_LAT   = 3;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_SSL  = 2'd1;
    localparam logic [1:0] REG_WPM  = 2'd2;

    localparam logic [1:0] K_ANY = 2'd0;
    localparam logic [1:0] K_A1  = 2'd1;
    localparam logic [1:0] K_A2  = 2'd2;

    localparam logic [1:0] SEQ_ID   = 2'd0;
    localparam logic [1:0] SEQ_PROG = 2'd1;
    localparam logic [1:0] SEQ_SEC  = 2'd2;
    localparam logic [1:0] SEQ_CHIP = 2'd3;

    localparam int LEN_ID    = 3;
    localparam int LEN_PROG  = 4;
    localparam int LEN_ERASE = 6;

    localparam logic [1:0] ID_SEL_DEVICE  = 2'd1;
    localparam logic [1:0] ID_SEL_PROTECT = 2'd2;

    localparam logic [7:0] MAKER_CODE  = 8'h01;
    localparam logic [7:0] DEVICE_CODE = 8'hA4;
    localparam logic [7:0] CMD_RESET   = 8'hF0;
    localparam logic [7:0] ERASED      = 8'hFF;

    localparam logic [11:0] MASK_M0 = 12'hFFF;
    localparam logic [11:0] A1_M0   = 12'hAAA;
    localparam logic [11:0] A2_M0   = 12'h555;
    localparam logic [11:0] MASK_M1 = 12'h7FF;
    localparam logic [11:0] A1_M1   = 12'h555;
    localparam logic [11:0] A2_M1   = 12'h2AA;

    localparam logic [2:0] SEQ_LEN [4] = '{3'd3, 3'd3, 3'd6, 3'd6};

    localparam logic [7:0] SEQ_VAL [4][6] = '{
        '{8'hAA, 8'h55, 8'h90, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 8'h55, 8'hA0, 8'h00, 8'h00, 8'h00},
        '{8'hAA, 8'h55, 8'h80, 8'hAA, 8'h55, 8'h30},
        '{8'hAA, 8'h55, 8'h80, 8'hAA, 8'h55, 8'h10}
    };

    localparam logic [1:0] SEQ_KIND [4][6] = '{
        '{K_A1, K_A2, K_A1, K_ANY, K_ANY, K_ANY},
        '{K_A1, K_A2, K_A1, K_ANY, K_ANY, K_ANY},
        '{K_A1, K_A2, K_A1, K_A1, K_A2, K_ANY},
        '{K_A1, K_A2, K_A1, K_A1, K_A2, K_ANY}
    };

    typedef struct packed {
        logic        mode;
        logic [4:0]  ssl;
        logic [31:0] wpm;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_EXEC,
        ST_RDWAIT,
        ST_SWEEP,
        ST_DONE
    } t_state;

    function automatic logic seq_ok(input logic [1:0] seq, input logic [3:0] pos,
                                    input logic [ADDR_BITS-1:0] addr,
                                    input logic [7:0] data, input logic mode);
        logic [11:0] a;
        logic [11:0] a1;
        logic [11:0] a2;
        logic [2:0]  p;
        logic        ok;
        a  = addr[11:0] & (mode ? MASK_M1 : MASK_M0);
        a1 = mode ? A1_M1 : A1_M0;
        a2 = mode ? A2_M1 : A2_M0;
        p  = pos[2:0];
        ok = 1'b1;
        if (pos < 4'(SEQ_LEN[seq])) begin
            if (data != SEQ_VAL[seq][p]) ok = 1'b0;
            if (SEQ_KIND[seq][p] == K_A1 && a != a1) ok = 1'b0;
            if (SEQ_KIND[seq][p] == K_A2 && a != a2) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

/* hdl/csf_mod.sv */
// Pipelined reduction of a byte address modulo the array size.
`timescale 1ns / 1ps
module csf_mod #(
    parameter int MODULUS = 65536,
    parameter int OUT_W   = 16
) (
    input  logic                          i_clk,
    input  logic [csf_pkg::ADDR_BITS-1:0] i_a,
    output logic [OUT_W-1:0]              o_r
);
    import csf_pkg::*;

    localparam int unsigned RECIP = (2 ** ADDR_BITS) / MODULUS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PW = ADDR_BITS + RECIP_W;
    localparam int WW = ADDR_BITS + 1;

    logic [ADDR_BITS-1:0] r_a1;
    logic [PW-1:0]        r_p;
    logic [WW-1:0]        r_r;
    logic [OUT_W-1:0]     r_q;
    logic [RECIP_W-1:0]   q_est;
    logic [WW-1:0]        n_r;
    logic [WW-1:0]        corr;

    assign q_est = r_p[PW-1 -: RECIP_W];
    assign n_r   = WW'(r_a1) - WW'(q_est) * WW'(MODULUS);
    assign corr  = (r_r >= WW'(MODULUS)) ? r_r - WW'(MODULUS) : r_r;

    always_ff @(posedge i_clk) begin
        r_a1 <= i_a;
        r_p  <= PW'(i_a) * PW'(RECIP);
        r_r  <= n_r;
        r_q  <= OUT_W'(corr);
    end

    assign o_r = r_q;

endmodule

/* hdl/csf_mem.sv */
// Single-port byte array with registered read data.
`timescale 1ns / 1ps
module csf_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

/* hdl/csf_ctrl.sv */
// Command sequencer: decodes each bus word and drives the array port.
`timescale 1ns / 1ps
module csf_ctrl #(
    parameter int FLASH_BYTES = 65536,
    parameter int LOG_SLOTS   = 8,
    parameter int AW          = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csf_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [csf_pkg::ADDR_BITS-1:0] i_address,
    input  logic [7:0]                    i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_read_data,
    output logic                          o_command_in_progress,
    output logic                          o_mem_we,
    output logic [AW-1:0]                 o_mem_addr,
    output logic [7:0]                    o_mem_wdata,
    input  logic [7:0]                    i_mem_rdata
);
    import csf_pkg::*;

    localparam int CW = $clog2(LOG_SLOTS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FLASH_BYTES - 1);
    localparam int SW = ADDR_BITS + 2;

    t_state r_state, n_state;
    logic [1:0]           r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [7:0]           r_wdata;
    logic [1:0]           r_wait, n_wait;
    logic [CW-1:0]        r_count, n_count;
    logic [3:0]           r_match, n_match;
    logic                 r_ident, n_ident;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_last, n_last;
    logic                 r_rmw, n_rmw;
    logic [7:0]           r_rd, n_rd;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_rd, n_out_rd;
    logic                 r_out_cip, n_out_cip;

    logic [AW-1:0]        addr_mod;
    logic [AW-1:0]        base_mod;
    logic [ADDR_BITS-1:0] base_raw;
    logic [ADDR_BITS-1:0] sect;
    logic                 prot;
    logic [3:0]           nm;
    logic [CW-1:0]        wc;
    logic                 log_full;
    logic                 cmd_valid;
    logic                 ident_enter;
    logic                 prog_go;
    logic                 sec_go;
    logic                 chip_go;
    logic                 clr;
    logic [SW-1:0]        sec_end;
    logic [AW-1:0]        sec_last;
    logic                 accept;
    logic                 out_free;

    assign base_raw = r_addr & ~((ADDR_BITS'(1) << i_cfg.ssl) - ADDR_BITS'(1));

    csf_mod #(.MODULUS(FLASH_BYTES), .OUT_W(AW)) u_mod_addr (
        .i_clk (i_clk),
        .i_a   (r_addr),
        .o_r   (addr_mod)
    );

    csf_mod #(.MODULUS(FLASH_BYTES), .OUT_W(AW)) u_mod_base (
        .i_clk (i_clk),
        .i_a   (base_raw),
        .o_r   (base_mod)
    );

    assign sect = r_addr >> i_cfg.ssl;
    assign prot = (sect < ADDR_BITS'(32)) ? i_cfg.wpm[sect[4:0]] : 1'b0;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nm[k] = ((r_count == '0) || r_match[k])
                    && seq_ok(2'(k), 4'(r_count), r_addr, r_wdata, i_cfg.mode);
        end
        wc          = r_count + CW'(1);
        log_full    = (r_count >= CW'(LOG_SLOTS));
        cmd_valid   = (nm[SEQ_ID] && wc < CW'(LEN_PROG))
                   || (nm[SEQ_PROG] && wc < CW'(LEN_PROG))
                   || (nm[SEQ_SEC] && wc < CW'(LEN_ERASE))
                   || (nm[SEQ_CHIP] && wc < CW'(LEN_ERASE));
        ident_enter = nm[SEQ_ID] && (wc == CW'(LEN_ID));
        prog_go     = nm[SEQ_PROG] && (wc >= CW'(LEN_PROG)) && !prot;
        sec_go      = nm[SEQ_SEC] && (wc >= CW'(LEN_ERASE)) && !prot;
        chip_go     = nm[SEQ_CHIP] && (wc >= CW'(LEN_ERASE));
        clr         = !cmd_valid || (r_wdata == CMD_RESET);
        sec_end     = SW'(base_mod) + (SW'(1) << i_cfg.ssl);
        if (i_cfg.ssl >= 5'(ADDR_BITS + 1) || sec_end >= SW'(FLASH_BYTES)) begin
            sec_last = LAST_ADDR;
        end else begin
            sec_last = AW'(sec_end - SW'(1));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_ptr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MOD;
            end
            ST_MOD: begin
                if (r_wait == 2'(MOD_LAT - 1)) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_op)
                    OP_READ: begin
                        if (!r_ident) n_state = ST_RDWAIT;
                    end
                    OP_WRITE: begin
                        if (!log_full) begin
                            if (prog_go) n_state = ST_RDWAIT;
                            else if (sec_go || chip_go) n_state = ST_SWEEP;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_SWEEP: begin
                if (r_ptr == r_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_wait      = '0;
        n_count     = r_count;
        n_match     = r_match;
        n_ident     = r_ident;
        n_ptr       = r_ptr;
        n_last      = r_last;
        n_rmw       = r_rmw;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_rd    = r_out_rd;
        n_out_cip   = r_out_cip;
        o_mem_we    = 1'b0;
        o_mem_addr  = addr_mod;
        o_mem_wdata = r_wdata;
        case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_ptr;
                o_mem_wdata = ERASED;
                n_ptr       = r_ptr + AW'(1);
            end
            ST_MOD: begin
                n_wait = r_wait + 2'd1;
            end
            ST_EXEC: begin
                n_rd  = 8'h00;
                n_rmw = 1'b0;
                case (r_op)
                    OP_READ: begin
                        if (r_ident) begin
                            n_count = '0;
                            case (r_addr[1:0])
                                ID_SEL_DEVICE:  n_rd = DEVICE_CODE;
                                ID_SEL_PROTECT: n_rd = {7'd0, prot};
                                default:        n_rd = MAKER_CODE;
                            endcase
                        end
                    end
                    OP_WRITE: begin
                        if (!log_full) begin
                            n_match = nm;
                            n_count = clr ? '0 : wc;
                            n_ident = clr ? 1'b0 : (ident_enter || r_ident);
                            n_rmw   = prog_go;
                            if (sec_go) begin
                                n_ptr  = base_mod;
                                n_last = sec_last;
                            end else if (chip_go) begin
                                n_ptr  = '0;
                                n_last = LAST_ADDR;
                            end
                        end
                    end
                    OP_PRELOAD: begin
                        o_mem_we = 1'b1;
                    end
                    default: n_rd = 8'h00;
                endcase
            end
            ST_RDWAIT: begin
                if (r_rmw) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = r_wdata & i_mem_rdata;
                end else begin
                    n_rd = i_mem_rdata;
                end
            end
            ST_SWEEP: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_ptr;
                o_mem_wdata = ERASED;
                n_ptr       = r_ptr + AW'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_rd;
                    n_out_cip   = (r_count != '0);
                end
            end
            default: n_wait = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_wait      <= '0;
            r_count     <= '0;
            r_ident     <= 1'b0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_count     <= n_count;
            r_ident     <= n_ident;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        r_match  <= n_match;
        r_last   <= n_last;
        r_rmw    <= n_rmw;
        r_rd     <= n_rd;
        r_out_rd <= n_out_rd;
        r_out_cip <= n_out_cip;
    end

    assign o_in_stall            = (r_state != ST_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_read_data           = r_out_rd;
    assign o_command_in_progress = r_out_cip;

endmodule

/* hdl/command_set_flash_memory_core.sv */
// Top level of the emulated byte-wide flash with unlock-cycle commands.
`timescale 1ns / 1ps
// Each bus word (read, write or preload) yields one result word. A word is
// taken only while the sequencer is idle and runs through a three-stage
// address reduction and one access of the single-port array. Array reads
// and program commands also wait on the array's registered read data. The
// next word is taken the cycle after the result is registered, even if
// that result is still held by the output side. Sector erase sweeps the
// array one byte a cycle, 2**sector_size_log2 bytes clipped at the array
// end; chip erase sweeps the whole array. After reset the array is cleared
// to 0xFF in one pass while the input stalls; register writes are taken
// throughout.
module command_set_flash_memory_core #(
    parameter int FLASH_BYTES = 65536,
    parameter int LOG_SLOTS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [csf_pkg::ADDR_BITS-1:0] i_address,
    input  logic [7:0]                    i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_read_data,
    output logic                          o_command_in_progress
);
    import csf_pkg::*;

    localparam int AW = $clog2(FLASH_BYTES);

    t_cfg          r_cfg;
    logic          cfg_wr;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= 1'b1;
            r_cfg.ssl  <= 5'd12;
            r_cfg.wpm  <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE: r_cfg.mode <= pwdata[0];
                REG_SSL:  r_cfg.ssl  <= pwdata[4:0];
                REG_WPM:  r_cfg.wpm  <= pwdata;
                default:  r_cfg.mode <= r_cfg.mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE: prdata = {31'd0, r_cfg.mode};
            REG_SSL:  prdata = {27'd0, r_cfg.ssl};
            REG_WPM:  prdata = r_cfg.wpm;
            default:  prdata = '0;
        endcase
    end

    csf_mem #(.DEPTH(FLASH_BYTES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    csf_ctrl #(.FLASH_BYTES(FLASH_BYTES), .LOG_SLOTS(LOG_SLOTS), .AW(AW)) u_ctrl (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_operation           (i_operation),
        .i_address             (i_address),
        .i_write_data          (i_write_data),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_read_data           (o_read_data),
        .o_command_in_progress (o_command_in_progress),
        .o_mem_we              (mem_we),
        .o_mem_addr            (mem_addr),
        .o_mem_wdata           (mem_wdata),
        .i_mem_rdata           (mem_rdata)
    );

endmodule
